>>> rtl/core/ssf_pkg.sv
// shared types, widths and codes for the state-space filter step
package ssf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ST_W      = 24;
  localparam int COEF_W    = 18;
  localparam int FRAC_W    = 16;
  localparam int MAX_ORDER = 3;
  localparam int DEF_ORDER = 3;
  localparam int ACT_W     = 2;
  localparam int IDX_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_FILTER = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_LOAD   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_COEF_1   = 3'd0,
    REG_FB_COEF_2   = 3'd1,
    REG_FB_COEF_3   = 3'd2,
    REG_OUT_COEF_1  = 3'd3,
    REG_OUT_COEF_2  = 3'd4,
    REG_OUT_COEF_3  = 3'd5,
    REG_DIRECT_GAIN = 3'd6
  } cfg_reg_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t [MAX_ORDER-1:0] fb;
    coef_t [MAX_ORDER-1:0] outw;
    coef_t                 direct;
  } coef_set_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic signed [ST_W-1:0]     new_head;
    logic                       saturated;
  } step_res_t;

endpackage

>>> rtl/core/state_space_filter_step.sv
// state-space filter step: companion-form siso filter with 16-bit stream in and out
//
// Each input beat is a command in s_tuser: filter one sample, clear the state, or load one
// state element. A beat enters an input register; from there the output and new state are
// computed in one pass (2*ORDER+1 parallel multiplies) and written to the state and the
// result register. One beat is taken every cycle unless m_tready holds a filter beat back.
// Clear and load beats change the state only and give no output beat. The result register
// lets a new beat enter while a finished one still waits on m_tready. Coefficients must be
// written through the cfg port only while the stream is idle; the block does not enforce
// this. Coefficients, state and valid flags clear on rst.
module state_space_filter_step import ssf_pkg::*; #(
  parameter int ORDER = DEF_ORDER
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [COEF_W-1:0]    cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,  // sample, state_index, state_value, zero pad
  input  logic [ACT_W-1:0]     s_tuser,  // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [SAMPLE_W-1:0]  m_tdata,  // out_sample
  output logic                 m_tuser   // saturated
);

  coef_set_t                  coefs;
  logic signed [ST_W-1:0]     state_vec [ORDER];
  logic                       s1_valid;
  logic                       s1_valid_next;
  logic [ACT_W-1:0]           s1_action;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic [IDX_W-1:0]           s1_index;
  logic signed [ST_W-1:0]     s1_value;
  logic                       s1_is_filter;
  logic                       s1_advance;
  logic                       in_beat;
  step_res_t                  res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_FB_COEF_1:   coefs.fb[0]   <= cfg_wdata;
        REG_FB_COEF_2:   coefs.fb[1]   <= cfg_wdata;
        REG_FB_COEF_3:   coefs.fb[2]   <= cfg_wdata;
        REG_OUT_COEF_1:  coefs.outw[0] <= cfg_wdata;
        REG_OUT_COEF_2:  coefs.outw[1] <= cfg_wdata;
        REG_OUT_COEF_3:  coefs.outw[2] <= cfg_wdata;
        REG_DIRECT_GAIN: coefs.direct  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  assign s1_is_filter  = (s1_action == ACT_FILTER);
  assign s1_advance    = s1_valid && (!s1_is_filter || !m_tvalid || m_tready);
  assign s_tready      = !s1_valid || s1_advance;
  assign in_beat       = s_tvalid && s_tready;
  assign s1_valid_next = in_beat || (s1_valid && !s1_advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_action <= s_tuser;
      s1_sample <= s_tdata[SAMPLE_W-1:0];
      s1_index  <= s_tdata[SAMPLE_W +: IDX_W];
      s1_value  <= s_tdata[SAMPLE_W+IDX_W +: ST_W];
    end
  end

  ssf_datapath #(
    .ORDER(ORDER)
  ) u_datapath (
    .coefs    (coefs),
    .state_vec(state_vec),
    .sample   (s1_sample),
    .res      (res)
  );

  // state vector
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ORDER; k++) begin
        state_vec[k] <= '0;
      end
    end else if (s1_advance) begin
      case (s1_action)
        ACT_FILTER: begin
          for (int k = ORDER - 1; k > 0; k--) begin
            state_vec[k] <= state_vec[k-1];
          end
          state_vec[0] <= res.new_head;
        end
        ACT_CLEAR: begin
          for (int k = 0; k < ORDER; k++) begin
            state_vec[k] <= '0;
          end
        end
        ACT_LOAD: begin
          for (int k = 0; k < ORDER; k++) begin
            if (s1_index == IDX_W'(k)) begin
              state_vec[k] <= s1_value;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance && s1_is_filter) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_is_filter) begin
      m_tdata <= res.out_sample;
      m_tuser <= res.saturated;
    end
  end

`ifndef SYNTH
  a_no_beat_for_cmd: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && !s1_is_filter && !(m_tvalid && !m_tready)) |=> !m_tvalid)
    else $error("output beat from a clear or load command");

  a_filter_gives_beat: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_is_filter) |=> m_tvalid)
    else $error("filter beat lost");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_action == ACT_CLEAR) |=> (state_vec[0] == '0))
    else $error("state not cleared");

  a_load_head: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_action == ACT_LOAD && s1_index == '0)
      |=> (state_vec[0] == $past(s1_value)))
    else $error("state element load missed");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_action)))
    else $error("stalled command dropped");
`endif

endmodule

>>> rtl/core/ssf_datapath.sv
// output and state-update arithmetic for one filter step
module ssf_datapath import ssf_pkg::*; #(
  parameter int ORDER = DEF_ORDER
) (
  input  coef_set_t                  coefs,
  input  logic signed [ST_W-1:0]     state_vec [ORDER],
  input  logic signed [SAMPLE_W-1:0] sample,
  output step_res_t                  res
);

  localparam int PROD_W = COEF_W + ST_W;
  localparam int DPROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W = PROD_W + 3;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(2 ** (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] X_MAX = ACC_W'(2 ** (ST_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] X_MIN = -X_MAX - ACC_W'(1);

  logic signed [PROD_W-1:0]  yprod [ORDER];
  logic signed [PROD_W-1:0]  xprod [ORDER];
  logic signed [DPROD_W-1:0] dprod;
  logic signed [ACC_W-1:0]   ysum;
  logic signed [ACC_W-1:0]   xsum;
  logic signed [ACC_W-1:0]   yr;
  logic signed [ACC_W-1:0]   xr;
  logic                      ysat;
  logic                      xsat;

  always_comb begin
    dprod = $signed(coefs.direct) * sample;
    ysum = ACC_W'(dprod);
    xsum = '0;
    for (int k = 0; k < ORDER; k++) begin
      yprod[k] = $signed(coefs.outw[k]) * state_vec[k];
      xprod[k] = $signed(coefs.fb[k]) * state_vec[k];
      ysum = ysum + ACC_W'(yprod[k]);
      xsum = xsum + ACC_W'(xprod[k]);
    end
    yr = (ysum + RND) >>> FRAC_W;
    xr = ((xsum + RND) >>> FRAC_W) + ACC_W'(sample);

    ysat = 1'b1;
    if (yr > Y_MAX) begin
      res.out_sample = Y_MAX[SAMPLE_W-1:0];
    end else if (yr < Y_MIN) begin
      res.out_sample = Y_MIN[SAMPLE_W-1:0];
    end else begin
      res.out_sample = yr[SAMPLE_W-1:0];
      ysat = 1'b0;
    end

    xsat = 1'b1;
    if (xr > X_MAX) begin
      res.new_head = X_MAX[ST_W-1:0];
    end else if (xr < X_MIN) begin
      res.new_head = X_MIN[ST_W-1:0];
    end else begin
      res.new_head = xr[ST_W-1:0];
      xsat = 1'b0;
    end

    res.saturated = ysat | xsat;
  end

endmodule

>>> tb/ssf_output_check.sv
// checker: mirrors coefficients and filter state from the observed beats and checks each output beat
`timescale 1ns / 1ps
module ssf_output_check import ssf_pkg::*; #(
  parameter int ORDER = DEF_ORDER
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [COEF_W-1:0]    cfg_wdata,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [ACT_W-1:0]     s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [SAMPLE_W-1:0]  m_tdata,
  input  logic                 m_tuser,
  output int                   fail_count,
  output int                   pending,
  output int                   result_count,
  output int                   sat_count
);

  localparam longint Y_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint Y_MIN = -(longint'(1) <<< (SAMPLE_W - 1));
  localparam longint X_MAX = (longint'(1) <<< (ST_W - 1)) - 1;
  localparam longint X_MIN = -(longint'(1) <<< (ST_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y;
    logic                       sat;
  } out_beat_t;

  coef_t                  fb_w [MAX_ORDER];
  coef_t                  out_w [MAX_ORDER];
  coef_t                  d_w;
  logic signed [ST_W-1:0] hist [MAX_ORDER];
  out_beat_t              output_due [$];

  function automatic longint half_up(longint v);
    return (v + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // output for one sample, then advance the companion-form state
  function automatic out_beat_t next_output(logic signed [SAMPLE_W-1:0] u);
    longint    ysum;
    longint    xsum;
    longint    y;
    longint    x0;
    int        k;
    out_beat_t r;
    ysum = longint'(d_w) * longint'(u);
    xsum = 0;
    for (k = 0; k < ORDER; k++) begin
      ysum += longint'(out_w[k]) * longint'(hist[k]);
      xsum += longint'(fb_w[k]) * longint'(hist[k]);
    end
    y  = half_up(ysum);
    x0 = half_up(xsum) + longint'(u);
    r.sat = (y > Y_MAX) || (y < Y_MIN) || (x0 > X_MAX) || (x0 < X_MIN);
    r.y   = SAMPLE_W'(clamp(y, Y_MIN, Y_MAX));
    for (k = ORDER - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = ST_W'(clamp(x0, X_MIN, X_MAX));
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t        want;
    logic [IDX_W-1:0] idx;
    int               k;
    if (rst) begin
      for (k = 0; k < MAX_ORDER; k++) begin
        fb_w[k]  = '0;
        out_w[k] = '0;
        hist[k]  = '0;
      end
      d_w = '0;
      output_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_FB_COEF_1:   fb_w[0]  = cfg_wdata;
          REG_FB_COEF_2:   fb_w[1]  = cfg_wdata;
          REG_FB_COEF_3:   fb_w[2]  = cfg_wdata;
          REG_OUT_COEF_1:  out_w[0] = cfg_wdata;
          REG_OUT_COEF_2:  out_w[1] = cfg_wdata;
          REG_OUT_COEF_3:  out_w[2] = cfg_wdata;
          REG_DIRECT_GAIN: d_w      = cfg_wdata;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        result_count++;
        if (output_due.size() == 0) begin
          $error("output beat with no sample waiting: out_sample %0d", $signed(m_tdata));
          fail_count++;
        end else begin
          want = output_due.pop_front();
          if (want.sat) sat_count++;
          if (m_tdata !== want.y) begin
            $error("out_sample: expected %0d, got %0d", want.y, $signed(m_tdata));
            fail_count++;
          end
          if (m_tuser !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        idx = s_tdata[SAMPLE_W +: IDX_W];
        case (s_tuser)
          ACT_FILTER: output_due.push_back(next_output(s_tdata[SAMPLE_W-1:0]));
          ACT_CLEAR:  for (k = 0; k < MAX_ORDER; k++) hist[k] = '0;
          ACT_LOAD:   if (idx < ORDER) hist[idx] = s_tdata[SAMPLE_W+IDX_W +: ST_W];
          default: ;
        endcase
      end
    end
    pending = output_due.size();
  end

endmodule

>>> tb/tb.sv
// testbench top: drives coefficient sets and filter, clear and load beats, then gives the verdict
`timescale 1ns / 1ps
module tb;
  import ssf_pkg::*;

  localparam logic [ACT_W-1:0]     ACT_UNDEF       = 2'd3;
  localparam logic [IDX_W-1:0]     IDX_NONE        = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 3'd7;
  localparam int                   ITEMS_PER_PHASE = 305;
  localparam int                   HOLD_CYCLES     = 400;
  localparam int                   POST_CYCLES     = 8;
  localparam int                   STUCK_LIMIT     = 2000;
  localparam logic [SAMPLE_W-1:0]  SMP_MAX         = 16'h7fff;
  localparam logic [SAMPLE_W-1:0]  SMP_MIN         = 16'h8000;
  localparam logic [ST_W-1:0]      ST_MAX          = 24'h7fffff;
  localparam logic [ST_W-1:0]      ST_MIN          = 24'h800000;
  localparam coef_t                C_MAX           = 18'h1ffff;
  localparam coef_t                C_MIN           = 18'h20000;
  localparam coef_t                C_ONE           = 18'h10000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [COEF_W-1:0]    cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [ACT_W-1:0]     s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [SAMPLE_W-1:0]  m_tdata;
  logic                 m_tuser;

  int fail_count, pending, result_count, sat_count;
  int n_filter, n_clear, n_load, n_ignored, n_sets;
  int send_idle, recv_idle, hold_req, stuck;

  state_space_filter_step dut (
    .clk, .rst, .cfg_wr_en, .cfg_addr, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  ssf_output_check chk (
    .clk, .rst, .cfg_wr_en, .cfg_addr, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .fail_count, .pending, .result_count, .sat_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: random back-pressure, or a long hold-off on request
  initial begin
    int seen;
    int left;
    seen = 0;
    left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return SAMPLE_W'(int'($urandom_range(512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [ST_W-1:0] rand_state();
    case ($urandom_range(9))
      0:       return ST_MAX;
      1:       return ST_MIN;
      2, 3:    return ST_W'(int'($urandom_range(200000)) - 100000);
      default: return ST_W'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef(bit full);
    if (full) return coef_t'($urandom);
    return coef_t'(int'($urandom_range(80000)) - 40000);
  endfunction

  task automatic send_beat(input logic [ACT_W-1:0] act, input logic [SAMPLE_W-1:0] smp,
                           input logic [IDX_W-1:0] idx, input logic [ST_W-1:0] val);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(IN_DATA_W - SAMPLE_W - IDX_W - ST_W){1'b0}}, val, idx, smp};
    do @(posedge clk); while (!s_tready);
    case (act)
      ACT_FILTER: n_filter++;
      ACT_CLEAR:  n_clear++;
      ACT_LOAD:   if (idx == IDX_NONE) n_ignored++; else n_load++;
      default:    n_ignored++;
    endcase
  endtask

  // stop sending and wait until every output beat has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (POST_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input coef_t val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_coefs(input coef_t f1, input coef_t f2, input coef_t f3, input coef_t o1,
                           input coef_t o2, input coef_t o3, input coef_t d);
    write_reg(REG_UNUSED, rand_coef(1'b1));
    write_reg(REG_FB_COEF_1, f1);
    write_reg(REG_FB_COEF_2, f2);
    write_reg(REG_FB_COEF_3, f3);
    write_reg(REG_OUT_COEF_1, o1);
    write_reg(REG_OUT_COEF_2, o2);
    write_reg(REG_OUT_COEF_3, o3);
    write_reg(REG_DIRECT_GAIN, d);
    cfg_wr_en <= 1'b0;
    n_sets++;
  endtask

  task automatic retune(input coef_t f1, input coef_t f2, input coef_t f3, input coef_t o1,
                        input coef_t o2, input coef_t o3, input coef_t d);
    settle();
    set_coefs(f1, f2, f3, o1, o2, o3, d);
  endtask

  task automatic run_phase(input int count);
    int                  done_n;
    int                  pick;
    logic [ACT_W-1:0]    act;
    logic [IDX_W-1:0]    idx;
    done_n = 0;
    while (done_n < count) begin
      pick = $urandom_range(99);
      if (pick < 72)      act = ACT_FILTER;
      else if (pick < 87) act = ACT_LOAD;
      else if (pick < 94) act = ACT_CLEAR;
      else                act = ACT_UNDEF;
      idx = IDX_W'($urandom_range(3));
      send_beat(act, rand_sample(), idx, rand_state());
      done_n++;
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    send_idle = 28;
    recv_idle = 79;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_coefs(coef_t'(32768), coef_t'(-16384), coef_t'(8192),
              C_ONE, coef_t'(-32768), coef_t'(16384), C_ONE);
    send_beat(ACT_FILTER, SMP_MAX, '0, '0);
    send_beat(ACT_FILTER, SMP_MIN, '0, '0);
    send_beat(ACT_FILTER, '0, '0, '0);
    send_beat(ACT_LOAD, '0, 2'd0, ST_MAX);
    send_beat(ACT_LOAD, '0, 2'd1, ST_MIN);
    send_beat(ACT_LOAD, '0, 2'd2, 24'h555555);
    send_beat(ACT_LOAD, '0, IDX_NONE, 24'h123456);
    send_beat(ACT_FILTER, 16'hffff, '0, '0);
    send_beat(ACT_UNDEF, SMP_MAX, 2'd0, ST_MIN);
    send_beat(ACT_FILTER, 16'h0001, '0, '0);
    send_beat(ACT_CLEAR, '0, '0, '0);
    send_beat(ACT_FILTER, '0, '0, '0);
    send_beat(ACT_LOAD, '0, 2'd0, ST_MIN);
    send_beat(ACT_FILTER, SMP_MIN, '0, '0);
    send_beat(ACT_LOAD, '0, 2'd1, ST_MAX);
    send_beat(ACT_LOAD, '0, 2'd2, ST_MIN);
    send_beat(ACT_FILTER, SMP_MAX, '0, '0);
    send_beat(ACT_FILTER, 16'h2aaa, '0, '0);
    send_beat(ACT_CLEAR, '0, '0, '0);
    send_beat(ACT_FILTER, 16'hd555, '0, '0);

    retune(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    run_phase(ITEMS_PER_PHASE);
    retune(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    run_phase(ITEMS_PER_PHASE);

    send_idle = 79;
    recv_idle = 28;
    retune(rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0),
           rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0));
    // output held off while samples keep coming, so the input side backs up
    send_idle = 0;
    hold_req++;
    repeat (40) send_beat(ACT_FILTER, rand_sample(), '0, '0);
    send_idle = 79;
    settle();
    run_phase(ITEMS_PER_PHASE);
    retune(rand_coef(1'b1), rand_coef(1'b1), rand_coef(1'b1), rand_coef(1'b1),
           rand_coef(1'b1), rand_coef(1'b1), rand_coef(1'b1));
    run_phase(ITEMS_PER_PHASE);

    send_idle = 0;
    recv_idle = 0;
    retune(rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0), '0, '0, '0, C_ONE);
    run_phase(ITEMS_PER_PHASE);
    retune(rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0),
           rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b1));
    run_phase(ITEMS_PER_PHASE);

    settle();
    @(negedge clk);
    $display("stimulus: %0d filter, %0d clear, %0d load, %0d ignored beats over %0d coef sets",
             n_filter, n_clear, n_load, n_ignored, n_sets);
    $display("checked %0d output beats, %0d of them flagged saturated", result_count, sat_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
